[rtl/core/mbrtu_pkg.sv]
// Shared types, codes and the CRC-16 byte update for the Modbus RTU response parser.
`default_nettype none
package mbrtu_pkg;

  localparam int unsigned CW = 12;  // width of length and count arithmetic

  typedef logic [7:0]  byte_t;
  typedef logic [1:0]  kind_t;
  typedef logic [1:0]  status_t;
  typedef logic [2:0]  func_t;
  typedef logic [10:0] count_t;
  typedef logic [15:0] crc_t;
  typedef logic        cfg_idx_t;

  localparam kind_t KIND_REG    = 2'd0;
  localparam kind_t KIND_BITS   = 2'd1;
  localparam kind_t KIND_STATUS = 2'd2;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_BAD_LEN  = 2'd1;
  localparam status_t ST_CRC_ERR  = 2'd2;
  localparam status_t ST_BAD_FUNC = 2'd3;

  localparam func_t FUNC_COILS    = 3'd1;
  localparam func_t FUNC_DISCRETE = 3'd2;
  localparam func_t FUNC_HOLDING  = 3'd3;
  localparam func_t FUNC_INPUT    = 3'd4;

  localparam cfg_idx_t CFG_EXPECTED_FUNCTION = 1'b0;
  localparam cfg_idx_t CFG_REQUESTED_COUNT   = 1'b1;

  localparam crc_t CRC_INIT = 16'hFFFF;
  localparam crc_t CRC_POLY = 16'hA001;

  localparam func_t  EXPECTED_FUNCTION_RST = FUNC_HOLDING;
  localparam count_t REQUESTED_COUNT_RST   = 11'd1;

  function automatic crc_t crc16_byte(input crc_t crc_in, input byte_t b);
    crc_t c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

[rtl/core/mbrtu_if.sv]
// Valid/ready channel interfaces for frame bytes, results and register writes.
`default_nettype none
interface mbrtu_in_if;
  import mbrtu_pkg::*;
  logic  valid;
  logic  ready;
  byte_t byte_value;
  logic  frame_end;
  modport source (output valid, output byte_value, output frame_end, input ready);
  modport sink   (input valid, input byte_value, input frame_end, output ready);
endinterface

interface mbrtu_out_if;
  import mbrtu_pkg::*;
  logic        valid;
  logic        ready;
  kind_t       result_kind;
  logic [15:0] data_value;
  status_t     frame_status;
  logic        last;
  modport source (output valid, output result_kind, output data_value,
                  output frame_status, output last, input ready);
  modport sink   (input valid, input result_kind, input data_value,
                  input frame_status, input last, output ready);
endinterface

interface mbrtu_cfg_if;
  import mbrtu_pkg::*;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  count_t   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[rtl/core/modbus_rtu_response_parser.sv]
// Modbus RTU read-response parser: running CRC-16, payload unpacking, frame status.
//
//   channel  | dir | carries
//   ---------+-----+---------------------------------------------------------
//   in_ch    | in  | byte_value, frame_end: one frame byte per transfer
//   out_ch   | out | result_kind, data_value, frame_status, last
//   cfg_ch   | in  | index, data: expected_function (0), requested_count (1)
//
// One byte per cycle unless a held result stalls the input: a byte is captured in
// the input register, then its result (if any) lands in the output register.
// The CRC update and parse logic between the two registers set the cycle.
// rst_n (synchronous) restores frame state and register defaults.
// A held result only stalls the input when the byte in the input register also has a result.
`default_nettype none
module modbus_rtu_response_parser
  import mbrtu_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 256
) (
  input  wire         clk,
  input  wire         rst_n,
  mbrtu_in_if.sink    in_ch,
  mbrtu_out_if.source out_ch,
  mbrtu_cfg_if.sink   cfg_ch
);

  localparam int unsigned PW = $clog2(MAX_FRAME_BYTES + 1);

  // configuration
  func_t  exp_func_r;
  count_t req_count_r;

  // input register
  logic  s1_valid_r;
  byte_t s1_byte_r;
  logic  s1_end_r;

  // frame state
  crc_t          crc_r, crc_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  byte_t         func_r, func_nxt;
  byte_t         plen_r, plen_nxt;
  byte_t         hold_r, hold_nxt;

  // result register
  logic        out_valid_r;
  kind_t       out_kind_r;
  logic [15:0] out_data_r;
  status_t     out_status_r;
  logic        out_last_r;

  logic        res_vld;
  kind_t       res_kind;
  logic [15:0] res_data;
  status_t     res_status;
  logic        s1_adv;

  logic [CW-1:0] pos_ext, plen_ext, rc_ext, need, d, first, left;
  logic          in_limit, is_reg, is_bit, bad_len;
  byte_t         mask;

  assign s1_adv      = s1_valid_r && (!res_vld || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_kind  = out_kind_r;
  assign out_ch.data_value   = out_data_r;
  assign out_ch.frame_status = out_status_r;
  assign out_ch.last         = out_last_r;

  always_comb begin
    pos_ext  = CW'(pos_r);
    plen_ext = CW'(plen_r);
    rc_ext   = CW'(req_count_r);
    in_limit = pos_ext < CW'(MAX_FRAME_BYTES);
    is_reg   = (exp_func_r == FUNC_HOLDING) || (exp_func_r == FUNC_INPUT);
    is_bit   = (exp_func_r == FUNC_COILS) || (exp_func_r == FUNC_DISCRETE);

    if (is_reg) begin
      need = {rc_ext[CW-2:0], 1'b0};
    end else if (is_bit) begin
      need = (rc_ext + CW'(7)) >> 3;
    end else begin
      need = '0;
    end
    bad_len = !in_limit || (pos_ext + CW'(1) < CW'(5)) ||
              (pos_ext + CW'(1) != plen_ext + CW'(5)) || (plen_ext < need);

    d     = pos_ext - CW'(3);
    first = {d[CW-4:0], 3'b000};
    left  = (rc_ext > first) ? rc_ext - first : '0;
    mask  = (left >= CW'(8)) ? 8'hFF : 8'((9'd1 << left[2:0]) - 9'd1);

    crc_nxt    = crc16_byte(crc_r, s1_byte_r);
    pos_nxt    = pos_r;
    func_nxt   = func_r;
    plen_nxt   = plen_r;
    hold_nxt   = hold_r;
    res_vld    = 1'b0;
    res_kind   = KIND_REG;
    res_data   = '0;
    res_status = ST_OK;

    if (s1_end_r) begin
      res_vld  = 1'b1;
      res_kind = KIND_STATUS;
      priority if (bad_len) begin
        res_status = ST_BAD_LEN;
      end else if (crc_nxt != '0) begin
        res_status = ST_CRC_ERR;
      end else if (!(is_reg || is_bit) || func_r != {5'b00000, exp_func_r}) begin
        res_status = ST_BAD_FUNC;
      end else begin
        res_status = ST_OK;
      end
      crc_nxt  = CRC_INIT;
      pos_nxt  = '0;
      func_nxt = '0;
      plen_nxt = '0;
      hold_nxt = '0;
    end else if (in_limit) begin
      pos_nxt = pos_r + PW'(1);
      if (pos_ext == CW'(1)) begin
        func_nxt = s1_byte_r;
      end else if (pos_ext == CW'(2)) begin
        plen_nxt = s1_byte_r;
      end else if (pos_ext >= CW'(3) && pos_ext < plen_ext + CW'(3) &&
                   func_r == {5'b00000, exp_func_r}) begin
        if (is_reg) begin
          if (!d[0]) begin
            hold_nxt = s1_byte_r;
          end else begin
            res_vld  = 1'b1;
            res_kind = KIND_REG;
            res_data = {hold_r, s1_byte_r};
          end
        end else if (is_bit) begin
          res_vld  = 1'b1;
          res_kind = KIND_BITS;
          res_data = {8'h00, s1_byte_r & mask};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_func_r  <= EXPECTED_FUNCTION_RST;
      req_count_r <= REQUESTED_COUNT_RST;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      crc_r       <= CRC_INIT;
      pos_r       <= '0;
      func_r      <= '0;
      plen_r      <= '0;
      hold_r      <= '0;
    end else begin
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          CFG_EXPECTED_FUNCTION: exp_func_r  <= cfg_ch.data[2:0];
          CFG_REQUESTED_COUNT:   req_count_r <= cfg_ch.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        crc_r  <= crc_nxt;
        pos_r  <= pos_nxt;
        func_r <= func_nxt;
        plen_r <= plen_nxt;
        hold_r <= hold_nxt;
      end
      if (s1_adv && res_vld) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.byte_value;
      s1_end_r  <= in_ch.frame_end;
    end
    if (s1_adv && res_vld) begin
      out_kind_r   <= res_kind;
      out_data_r   <= res_data;
      out_status_r <= res_status;
      out_last_r   <= s1_end_r;
    end
  end

endmodule
`default_nettype wire
